[rtl/tlbpt_pkg.sv]
// Shared types and constants for the TLB and page table address translator.
// No dependencies; the TLB, the top level and the checker import this package.
package tlbpt_pkg;

    localparam int ADDR_W       = 16;
    localparam int PAGE_W       = 8;
    localparam int OFFSET_W     = 8;
    localparam int FRAME_W      = 8;
    localparam int CNT_W        = 32;
    localparam int PAGE_ENTRIES = 256;

    // Output tdata layout, lowest bit first.
    localparam int OUT_PHYS_LSB  = 0;
    localparam int OUT_HIT_BIT   = 16;
    localparam int OUT_FAULT_BIT = 17;
    localparam int OUT_ACNT_LSB  = 18;
    localparam int OUT_FCNT_LSB  = 50;
    localparam int OUT_HCNT_LSB  = 82;
    localparam int OUT_USED_W    = 114;
    localparam int OUT_TDATA_W   = 120;

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE    = 2'b01,
        ST_RESOLVE = 2'b10
    } state_t;

    // Result of a TLB lookup, valid in the cycle after the lookup is issued.
    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } tlb_lookup_t;

    // Fill command: write a page and frame pair into the TLB.
    typedef struct packed {
        logic               en;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } tlb_fill_t;

endpackage

[rtl/tlbpt_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tlbpt_tlb.sv]
// Fully associative TLB: tag and valid registers with a parallel compare,
// frame numbers in a tlbpt_ram. Depends on tlbpt_pkg and tlbpt_ram.
module tlbpt_tlb
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              lookup_en,
    input  logic [PAGE_W-1:0] lookup_page,
    output tlb_lookup_t       result,
    input  tlb_fill_t         fill
);

    localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    logic [PAGE_W-1:0]      tag_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0]       fifo_ptr_reg;
    logic                   hit_reg;

    logic [TLB_ENTRIES-1:0] match;
    logic                   any_hit;
    logic [IDX_W-1:0]       hit_idx;
    logic [IDX_W-1:0]       free_idx;
    logic                   all_valid;
    logic [IDX_W-1:0]       fill_slot;
    logic [FRAME_W-1:0]     frame_rdata;

    // Tag compare in every slot; the lowest matching slot wins.
    always_comb
    begin
        any_hit = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (tag_reg[i] == lookup_page);
        end
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                any_hit = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    // Fill slot: the lowest invalid slot, or the FIFO slot when all are valid.
    always_comb
    begin
        all_valid = &valid_reg;
        free_idx  = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
        fill_slot = all_valid ? fifo_ptr_reg : free_idx;
    end

    // Valid bits, FIFO pointer and registered hit flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            fifo_ptr_reg <= '0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            if (lookup_en)
            begin
                hit_reg <= any_hit;
            end
            if (fill.en)
            begin
                valid_reg[fill_slot] <= 1'b1;
                if (all_valid)
                begin
                    fifo_ptr_reg <= (fifo_ptr_reg == IDX_W'(TLB_ENTRIES - 1)) ?
                                    '0 : fifo_ptr_reg + 1'b1;
                end
            end
        end
    end

    // Tags are payload and need no reset.
    always_ff @(posedge clk)
    begin
        if (fill.en)
        begin
            tag_reg[fill_slot] <= fill.page;
        end
    end

    // Frame numbers, read at the matching slot.
    tlbpt_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (TLB_ENTRIES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (fill.en),
        .waddr (fill_slot),
        .wdata (fill.frame),
        .re    (lookup_en),
        .raddr (hit_idx),
        .rdata (frame_rdata)
    );

    assign result.hit   = hit_reg;
    assign result.frame = frame_rdata;

endmodule

[rtl/tlb_page_table_translator_top.sv]
// The result is registered in the resolve step, once the output register is free.
// One request at a time: the page table RAM is read with the request and written
// back in the resolve step; the TLB compare runs alongside.
// A full output register holds the controller in its resolve step until taken.
// Reset clears all valid bits, pointers and counters at once; no clearing pass.
module tlb_page_table_translator_top
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = 16,
    parameter int FRAME_TOTAL = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // logical_addr[15:0]
    input  logic [ADDR_W-1:0]      s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // phys_addr[15:0], tlb_hit[16], page_fault[17], address_count[49:18],
    // fault_count[81:50], hit_count[113:82], zero fill[119:114]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    state_t state_reg, state_next;

    logic [PAGE_W-1:0]       page_reg;
    logic [OFFSET_W-1:0]     offset_reg;
    logic [FRAME_W-1:0]      frame_ptr_reg;
    logic [PAGE_ENTRIES-1:0] pt_valid_reg;
    logic [CNT_W-1:0]        addr_cnt_reg, addr_cnt_next;
    logic [CNT_W-1:0]        fault_cnt_reg, fault_cnt_next;
    logic [CNT_W-1:0]        hit_cnt_reg, hit_cnt_next;
    logic                    out_valid_reg;
    logic [OUT_TDATA_W-1:0]  out_data_reg;

    logic                    accept;
    logic                    done;
    logic                    fault;
    logic [FRAME_W-1:0]      frame;
    logic [FRAME_W-1:0]      pt_rdata;
    tlb_lookup_t             tlb_res;
    tlb_fill_t               tlb_fill;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign done     = (state_reg == ST_RESOLVE) && (!out_valid_reg || m_tready);

    // TLB lookup is issued with the request; results arrive in the resolve step.
    tlbpt_tlb #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_tlb (
        .clk         (clk),
        .rst_n       (rst_n),
        .lookup_en   (accept),
        .lookup_page (s_tdata[ADDR_W-1:OFFSET_W]),
        .result      (tlb_res),
        .fill        (tlb_fill)
    );

    // Page table frames; valid bits live in flip-flops.
    tlbpt_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (PAGE_ENTRIES)
    ) u_pt_ram (
        .clk   (clk),
        .we    (done && fault),
        .waddr (page_reg),
        .wdata (frame),
        .re    (accept),
        .raddr (s_tdata[ADDR_W-1:OFFSET_W]),
        .rdata (pt_rdata)
    );

    // Frame selection: TLB, then page table, then a newly assigned frame.
    always_comb
    begin
        fault = !tlb_res.hit && !pt_valid_reg[page_reg];
        if (tlb_res.hit)
        begin
            frame = tlb_res.frame;
        end
        else if (!fault)
        begin
            frame = pt_rdata;
        end
        else
        begin
            frame = frame_ptr_reg;
        end
        tlb_fill.en    = done && !tlb_res.hit;
        tlb_fill.page  = page_reg;
        tlb_fill.frame = frame;
    end

    // Running counts including the current request.
    always_comb
    begin
        addr_cnt_next  = addr_cnt_reg + 1'b1;
        fault_cnt_next = fault ? fault_cnt_reg + 1'b1 : fault_cnt_reg;
        hit_cnt_next   = tlb_res.hit ? hit_cnt_reg + 1'b1 : hit_cnt_reg;
    end

    // Controller sequence.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, pointers, valid bits and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            frame_ptr_reg <= '0;
            pt_valid_reg  <= '0;
            addr_cnt_reg  <= '0;
            fault_cnt_reg <= '0;
            hit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                addr_cnt_reg  <= addr_cnt_next;
                fault_cnt_reg <= fault_cnt_next;
                hit_cnt_reg   <= hit_cnt_next;
                out_valid_reg <= 1'b1;
                if (fault)
                begin
                    pt_valid_reg[page_reg] <= 1'b1;
                    frame_ptr_reg <= (frame_ptr_reg == FRAME_W'(FRAME_TOTAL - 1)) ?
                                     '0 : frame_ptr_reg + 1'b1;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg   <= s_tdata[ADDR_W-1:OFFSET_W];
            offset_reg <= s_tdata[OFFSET_W-1:0];
        end
        if (done)
        begin
            out_data_reg <= {
                (OUT_TDATA_W - OUT_USED_W)'(0),
                hit_cnt_next,
                fault_cnt_next,
                addr_cnt_next,
                fault,
                tlb_res.hit,
                frame,
                offset_reg
            };
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[rtl/tlbpt_checker.sv]
// Port-level checks for the translator, bound to its top level.
// Depends on tlbpt_pkg and tlb_page_table_translator_top.
module tlbpt_checker
    import tlbpt_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // One request at a time: the block is busy right after an accepted request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while busy");

    // A TLB hit never reports a page fault.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[OUT_HIT_BIT] && m_tdata[OUT_FAULT_BIT]))
        else $error("hit and fault both set");

    // A fresh result follows an accepted request, with the resolve step between them.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a request");

endmodule

bind tlb_page_table_translator_top tlbpt_checker u_tlbpt_checker (.*);
